// ===== src/itda_pkg.sv =====
// Package for the decimal text formatter: widths, ASCII codes and the
// shift-add-3 digit correction. No dependencies.
`timescale 1ns / 1ps

package itda_pkg;

  localparam int VAL_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(VAL_W);
  localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  function automatic logic [3:0] dabble_adjust(input logic [3:0] d);
    dabble_adjust = (d >= 4'd5) ? 4'(d + 4'd3) : d;
  endfunction

endpackage

// ===== src/itda_if.sv =====
// Valid/ready channel interfaces for the formatter: integer in, characters out.
// Depends on itda_pkg.
`timescale 1ns / 1ps

interface itda_num_if import itda_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itda_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ===== src/itda_dabble.sv =====
// Iterative binary to BCD converter, one shift-add-3 step per cycle.
// Depends on itda_pkg.
`timescale 1ns / 1ps

module itda_dabble import itda_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] mag,
  output logic             done,
  output logic [BCD_W-1:0] bcd
);

  logic [VAL_W-1:0] shreg;
  logic [BCD_W-1:0] bcd_reg;
  logic [BCD_W-1:0] adj;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      adj[4*k +: 4] = dabble_adjust(bcd_reg[4*k +: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shreg   <= mag;
        bcd_reg <= '0;
        cnt     <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        bcd_reg <= {adj[BCD_W-2:0], shreg[VAL_W-1]};
        shreg   <= {shreg[VAL_W-2:0], 1'b0};
        cnt     <= CNT_W'(cnt + 1'b1);
        if (cnt == CNT_W'(VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign bcd = bcd_reg;

endmodule

// ===== src/int_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text.
// Channel num (valid/ready) carries one signed value per transfer; channel
// text returns its characters one per transfer, most significant digit
// first, with a leading '-' for negative values and last_char set on the
// final character. Zero gives a single '0'; -2147483648 gives eleven
// characters.
// num.ready is high only while the block is idle. After a transfer the
// value is converted to BCD by a shift-add-3 unit at one bit per cycle,
// leading zero digits are dropped at one per cycle (up to nine), then the
// characters are loaded into the output register one by one. A new number
// is accepted once the last character has been loaded; the time per number
// is set by the 32-step conversion loop and the serial output.
// The text channel has an output register: a stalled receiver holds the
// current character and pauses the sequencer, but never loses data.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// pending character.
// Depends on itda_pkg, itda_if and itda_dabble.
`timescale 1ns / 1ps

module int_to_decimal_ascii import itda_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  itda_num_if.sink      num,
  itda_char_if.source   text
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t            state;
  logic              neg;
  logic [BCD_W-1:0]  digits;
  logic [LEFT_W-1:0] left;
  logic              out_valid;
  logic [7:0]        out_char;
  logic              out_last;

  logic              start;
  logic [VAL_W-1:0]  mag;
  logic              conv_done;
  logic [BCD_W-1:0]  bcd;
  logic              load;
  logic              out_load;
  logic [3:0]        top_digit;

  assign start     = (state == S_IDLE) && num.valid;
  assign mag       = num.value[VAL_W-1] ? VAL_W'(~num.value + 1'b1) : VAL_W'(num.value);
  assign load      = !out_valid || text.ready;
  assign out_load  = load && (state inside {S_SIGN, S_EMIT});
  assign top_digit = digits[BCD_W-1 -: 4];

  itda_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !text.ready);
      case (state)
        S_IDLE: begin
          if (num.valid) begin
            neg   <= num.value[VAL_W-1];
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_done) begin
            digits <= bcd;
            left   <= LEFT_W'(NUM_DIGITS);
            state  <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (top_digit == 4'd0 && left > LEFT_W'(1)) begin
            digits <= {digits[BCD_W-5:0], 4'd0};
            left   <= LEFT_W'(left - 1'b1);
          end else begin
            state <= neg ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (load) begin
            out_char  <= ASCII_MINUS;
            out_last  <= 1'b0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load) begin
            out_char  <= 8'(ASCII_ZERO + {4'd0, top_digit});
            out_last  <= (left == LEFT_W'(1));
            digits    <= {digits[BCD_W-5:0], 4'd0};
            left      <= LEFT_W'(left - 1'b1);
            if (left == LEFT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign num.ready      = (state == S_IDLE);
  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last_char = out_last;

endmodule
